/* rtl/djc_pkg.sv */
// Shared types, constants and the jet channel function of the depth colormap block.
// Used by djc_div_cell and depth_jet_colormap_top; depends on nothing.
package djc_pkg;

	localparam int RAW_W   = 16;
	localparam int REG_W   = 16;
	localparam int CH_W    = 8;
	localparam int FRAC_W  = 12;
	localparam int MM_W    = RAW_W + REG_W;
	localparam int Q_BITS  = 16;
	localparam int T_W     = Q_BITS + 1;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_NEAR  = 2'd0;
	localparam logic [IDX_W-1:0] REG_FAR   = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE = 2'd2;

	localparam logic [REG_W-1:0] NEAR_RST  = 16'd0;
	localparam logic [REG_W-1:0] FAR_RST   = 16'd5000;
	localparam logic [REG_W-1:0] SCALE_RST = 16'd4096;

	localparam logic [T_W-1:0]   ONE_Q16      = 17'd65536;
	localparam logic [T_W+1:0]   ONE_HALF_Q16 = 19'd98304;

	localparam logic [1:0] K_RED   = 2'd3;
	localparam logic [1:0] K_GREEN = 2'd2;
	localparam logic [1:0] K_BLUE  = 2'd1;

	// one word moving between divider cells
	typedef struct packed {
		logic              valid;
		logic              blank;
		logic              near_sat;
		logic              far_sat;
		logic [Q_BITS-1:0] rem;
		logic [Q_BITS-1:0] num;
		logic [Q_BITS-1:0] quo;
	} div_word_t;

	function automatic logic [CH_W-1:0] jet_channel(input logic [T_W-1:0] t, input logic [1:0] k);
		logic [T_W+1:0] four_t;
		logic [T_W+1:0] centre;
		logic [T_W+1:0] gap;
		logic [T_W+1:0] v;
		logic [T_W+9:0] prod;
		four_t = {t, 2'b00};
		centre = {1'b0, k, 16'd0};
		gap    = (four_t >= centre) ? (four_t - centre) : (centre - four_t);
		v      = (gap >= ONE_HALF_Q16) ? '0 : (ONE_HALF_Q16 - gap);
		if (v > {2'b00, ONE_Q16}) begin
			v = {2'b00, ONE_Q16};
		end
		prod = {v, 8'd0} - {8'd0, v};
		return prod[23:16];
	endfunction

endpackage

/* rtl/djc_div_cell.sv */
// One restoring division step: shifts a numerator bit into the remainder,
// subtracts the span when it fits and appends a quotient bit. Uses djc_pkg.
module djc_div_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [djc_pkg::REG_W-1:0] span,
	input  djc_pkg::div_word_t        word_in,
	output djc_pkg::div_word_t        word_out
);

	logic [djc_pkg::Q_BITS:0]   trial;
	logic                       fits;
	djc_pkg::div_word_t         nxt;
	djc_pkg::div_word_t         word_q;

	always_comb begin
		trial        = {word_in.rem, word_in.num[djc_pkg::Q_BITS-1]};
		fits         = (trial >= {1'b0, span});
		nxt          = word_in;
		nxt.rem      = fits ? djc_pkg::Q_BITS'(trial - {1'b0, span})
		                    : trial[djc_pkg::Q_BITS-1:0];
		nxt.num      = {word_in.num[djc_pkg::Q_BITS-2:0], 1'b0};
		nxt.quo      = {word_in.quo[djc_pkg::Q_BITS-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q <= nxt;
		end
	end

	assign word_out = word_q;

endmodule

/* rtl/depth_jet_colormap_top.sv */
// Top level of the depth jet colormap: config registers, multiply and offset
// stages, the divider cell chain and the color output stage. Uses djc_pkg, djc_div_cell.
//
// Usage:
//   Pixel channel: a word is taken at each rising edge with start high and busy
//   low. busy stays low, so one pixel can enter every cycle.
//   Result channel: result_valid is high for one cycle with red, green, blue.
//   The receiver cannot stall; results must be taken when shown.
//   Pipeline: multiply, offset, 16 divider cells, color stage. Throughput: one
//   pixel per cycle, set by the fully pipelined chain of 16 one-bit divider cells.
//   Config channel: cfg_valid/cfg_ready write cfg_data to register cfg_index
//   (0 near, 1 far, 2 scale; index 3 ignored). cfg_ready is always high.
//   Write registers only while no pixel is in flight.
//   Reset: empties the pipeline and loads near 0, far 5000, scale 1.0 (Q4.12).
module depth_jet_colormap_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [djc_pkg::RAW_W-1:0] depth_raw,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [djc_pkg::IDX_W-1:0] cfg_index,
	input  logic [djc_pkg::REG_W-1:0] cfg_data,
	output logic                      result_valid,
	output logic [djc_pkg::CH_W-1:0]  red,
	output logic [djc_pkg::CH_W-1:0]  green,
	output logic [djc_pkg::CH_W-1:0]  blue
);

	localparam int QB = djc_pkg::Q_BITS;

	logic [djc_pkg::REG_W-1:0] near_q;
	logic [djc_pkg::REG_W-1:0] far_q;
	logic [djc_pkg::REG_W-1:0] scale_q;
	logic [djc_pkg::REG_W-1:0] span;

	logic                      valid_s1;
	logic                      blank_s1;
	logic [djc_pkg::MM_W-1:0]  mm_s1;

	logic [djc_pkg::MM_W-1:0]  near_q12;
	logic [djc_pkg::MM_W-1:0]  span_q12;
	logic [djc_pkg::MM_W-1:0]  offset;
	djc_pkg::div_word_t        head;
	djc_pkg::div_word_t        chain [0:QB];

	logic [djc_pkg::T_W-1:0]   t_val;
	logic                      valid_q;
	logic [djc_pkg::CH_W-1:0]  red_q;
	logic [djc_pkg::CH_W-1:0]  green_q;
	logic [djc_pkg::CH_W-1:0]  blue_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q  <= djc_pkg::NEAR_RST;
			far_q   <= djc_pkg::FAR_RST;
			scale_q <= djc_pkg::SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				djc_pkg::REG_NEAR:  near_q  <= cfg_data;
				djc_pkg::REG_FAR:   far_q   <= cfg_data;
				djc_pkg::REG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign span = (far_q > near_q) ? (far_q - near_q) : djc_pkg::REG_W'(1);

	// stage 1: depth in mm, Q.12
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		blank_s1 <= (depth_raw == '0);
		mm_s1    <= djc_pkg::MM_W'(depth_raw) * djc_pkg::MM_W'(scale_q);
	end

	// stage 2 feed: offset from near limit, saturation checks, divider seed
	always_comb begin
		near_q12      = {near_q, {djc_pkg::FRAC_W{1'b0}}};
		span_q12      = {{(djc_pkg::MM_W-djc_pkg::REG_W-djc_pkg::FRAC_W){1'b0}},
		                 span, {djc_pkg::FRAC_W{1'b0}}};
		offset        = mm_s1 - near_q12;
		head.valid    = valid_s1;
		head.blank    = blank_s1;
		head.near_sat = (mm_s1 <= near_q12);
		head.far_sat  = (offset >= span_q12);
		head.rem      = offset[djc_pkg::FRAC_W +: QB];
		head.num      = {offset[djc_pkg::FRAC_W-1:0], {(QB-djc_pkg::FRAC_W){1'b0}}};
		head.quo      = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else begin
			chain[0] <= head;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_cell
		djc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.span     (span),
			.word_in  (chain[i]),
			.word_out (chain[i+1])
		);
	end

	// color stage
	always_comb begin
		if (chain[QB].near_sat) begin
			t_val = djc_pkg::ONE_Q16;
		end else if (chain[QB].far_sat) begin
			t_val = '0;
		end else begin
			t_val = djc_pkg::ONE_Q16 - {1'b0, chain[QB].quo};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= chain[QB].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chain[QB].blank) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else begin
			red_q   <= djc_pkg::jet_channel(t_val, djc_pkg::K_RED);
			green_q <= djc_pkg::jet_channel(t_val, djc_pkg::K_GREEN);
			blue_q  <= djc_pkg::jet_channel(t_val, djc_pkg::K_BLUE);
		end
	end

	assign result_valid = valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;

endmodule

/* test/tb_depth_jet_colormap_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for depth_jet_colormap_top: drives raw depth words and
// register writes, predicts each RGB word and checks it on the result strobe.
// Depends on djc_pkg and depth_jet_colormap_top.
module tb_depth_jet_colormap_top;

	localparam int LAT       = 18;
	localparam int PER_PHASE = 120;
	localparam int LIMIT     = 4000;

	localparam logic [djc_pkg::IDX_W-1:0] REG_NONE   = 2'd3;
	localparam logic [18:0]               T_ONE      = 19'd65536;
	localparam logic [18:0]               T_ONE_HALF = 19'd98304;

	typedef struct packed {
		logic [djc_pkg::CH_W-1:0] red;
		logic [djc_pkg::CH_W-1:0] green;
		logic [djc_pkg::CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [djc_pkg::IDX_W-1:0] index;
		logic [djc_pkg::REG_W-1:0] data;
	} reg_write_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [djc_pkg::RAW_W-1:0] depth_raw = '0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [djc_pkg::IDX_W-1:0] cfg_index = '0;
	logic [djc_pkg::REG_W-1:0] cfg_data = '0;
	logic                      result_valid;
	logic [djc_pkg::CH_W-1:0]  red;
	logic [djc_pkg::CH_W-1:0]  green;
	logic [djc_pkg::CH_W-1:0]  blue;

	logic [djc_pkg::REG_W-1:0] near_mm    = djc_pkg::NEAR_RST;
	logic [djc_pkg::REG_W-1:0] far_mm     = djc_pkg::FAR_RST;
	logic [djc_pkg::REG_W-1:0] unit_scale = djc_pkg::SCALE_RST;

	logic [djc_pkg::RAW_W-1:0] raw_backlog[$];
	reg_write_t                reg_writes[$];
	rgb_t                      rgb_expected[$];
	logic                      no_gaps = 1'b0;
	int                        mismatches = 0;
	int                        quiet_cycles = 0;

	depth_jet_colormap_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.depth_raw    (depth_raw),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [djc_pkg::CH_W-1:0] ramp_level(input logic [16:0] t,
			input logic [1:0] k);
		logic [18:0] four_t;
		logic [18:0] mid;
		logic [18:0] gap;
		logic [18:0] lvl;
		logic [26:0] prod;
		four_t = {t, 2'b00};
		mid    = {1'b0, k, 16'd0};
		gap    = (four_t >= mid) ? (four_t - mid) : (mid - four_t);
		lvl    = (gap >= T_ONE_HALF) ? 19'd0 : (T_ONE_HALF - gap);
		if (lvl > T_ONE) begin
			lvl = T_ONE;
		end
		prod = {8'd0, lvl} * 27'd255;
		return prod[23:16];
	endfunction

	function automatic rgb_t jet_pixel(input logic [djc_pkg::RAW_W-1:0] raw);
		rgb_t        px;
		logic [15:0] span;
		logic [31:0] mm;
		logic [31:0] base;
		logic [35:0] ratio;
		logic [16:0] t;
		px = '0;
		if (raw != '0) begin
			span = (far_mm > near_mm) ? (far_mm - near_mm) : 16'd1;
			mm   = {16'd0, raw} * {16'd0, unit_scale};
			base = {4'd0, near_mm, 12'd0};
			if (mm <= base) begin
				t = 17'h10000;
			end else begin
				ratio = {mm - base, 4'd0};
				ratio = ratio / {20'd0, span};
				t     = (ratio >= 36'h10000) ? 17'd0 : (17'h10000 - ratio[16:0]);
			end
			px.red   = ramp_level(t, djc_pkg::K_RED);
			px.green = ramp_level(t, djc_pkg::K_GREEN);
			px.blue  = ramp_level(t, djc_pkg::K_BLUE);
		end
		return px;
	endfunction

	// mostly depths around the configured range, plus zeros, extremes and noise
	function automatic logic [djc_pkg::RAW_W-1:0] pick_raw();
		int unsigned sel;
		int unsigned lo;
		int unsigned hi;
		int unsigned margin;
		int unsigned mm_pick;
		logic [47:0] r;
		sel = $urandom_range(99);
		if (sel < 8) begin
			return '0;
		end
		if (sel < 14) begin
			return ($urandom_range(1) != 0) ? 16'hFFFF : 16'd1;
		end
		if (sel < 42 || unit_scale == '0) begin
			return 16'($urandom_range(65535));
		end
		lo      = near_mm;
		hi      = (far_mm > near_mm) ? far_mm : near_mm + 2;
		margin  = (hi - lo) / 8 + 1;
		lo      = (lo > margin) ? lo - margin : 0;
		hi      = hi + margin;
		mm_pick = $urandom_range(hi, lo);
		r       = {4'd0, mm_pick[31:0], 12'd0} / {32'd0, unit_scale};
		r       = r + 48'($urandom_range(2));
		if (r > 48'hFFFF) begin
			return 16'hFFFF - 16'($urandom_range(3));
		end
		return r[15:0];
	endfunction

	task automatic feed_random(input int count);
		for (int i = 0; i < count; i++) begin
			raw_backlog.push_back(pick_raw());
		end
	endtask

	task automatic settle();
		while (raw_backlog.size() != 0 || reg_writes.size() != 0 || rgb_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (LAT + 2) @(posedge clk);
	endtask

	task automatic configure(input logic [djc_pkg::REG_W-1:0] near,
			input logic [djc_pkg::REG_W-1:0] far, input logic [djc_pkg::REG_W-1:0] scale);
		reg_write_t w;
		w.index = djc_pkg::REG_NEAR;
		w.data  = near;
		reg_writes.push_back(w);
		w.index = djc_pkg::REG_FAR;
		w.data  = far;
		reg_writes.push_back(w);
		w.index = djc_pkg::REG_SCALE;
		w.data  = scale;
		reg_writes.push_back(w);
		while (reg_writes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_phase(input logic [djc_pkg::REG_W-1:0] near,
			input logic [djc_pkg::REG_W-1:0] far, input logic [djc_pkg::REG_W-1:0] scale);
		configure(near, far, scale);
		feed_random(PER_PHASE);
		settle();
	endtask

	always @(posedge clk) begin : drive_proc
		logic pause;
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (start && !busy) begin
				rgb_expected.push_back(jet_pixel(depth_raw));
				void'(raw_backlog.pop_front());
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					djc_pkg::REG_NEAR: begin
						near_mm = cfg_data;
					end
					djc_pkg::REG_FAR: begin
						far_mm = cfg_data;
					end
					djc_pkg::REG_SCALE: begin
						unit_scale = cfg_data;
					end
					default: begin
					end
				endcase
				void'(reg_writes.pop_front());
			end

			pause = !no_gaps && ($urandom_range(99) < 22);
			if (raw_backlog.size() != 0 && !pause) begin
				start     <= 1'b1;
				depth_raw <= raw_backlog[0];
			end else begin
				start     <= 1'b0;
				depth_raw <= 16'($urandom);
			end

			pause = !no_gaps && ($urandom_range(99) < 22);
			if (reg_writes.size() != 0 && !pause) begin
				cfg_valid <= 1'b1;
				cfg_index <= reg_writes[0].index;
				cfg_data  <= reg_writes[0].data;
			end else begin
				cfg_valid <= 1'b0;
				cfg_index <= 2'($urandom);
				cfg_data  <= 16'($urandom);
			end
		end
	end

	always @(posedge clk) begin : check_proc
		rgb_t want;
		if (arst_n && result_valid) begin
			if (rgb_expected.size() == 0) begin
				$error("unexpected word red %0d green %0d blue %0d", red, green, blue);
				mismatches++;
			end else begin
				want = rgb_expected.pop_front();
				if (red !== want.red) begin
					$error("red expected %0d got %0d", want.red, red);
					mismatches++;
				end
				if (green !== want.green) begin
					$error("green expected %0d got %0d", want.green, green);
					mismatches++;
				end
				if (blue !== want.blue) begin
					$error("blue expected %0d got %0d", want.blue, blue);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog_proc
		if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= LIMIT) begin
			$display("FAIL depth_jet_colormap_top");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stim_proc
		logic [djc_pkg::REG_W-1:0] near;
		reg_write_t                junk;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: invalid pixel, extremes, ramp breakpoints and both ends
		raw_backlog = '{16'd0, 16'd1, 16'hFFFF, 16'd5000, 16'd4999, 16'd5001, 16'd2500,
			16'd1250, 16'd3750, 16'd625, 16'd1875, 16'd3125, 16'd4375, 16'd624, 16'd626,
			16'h5555, 16'hAAAA, 16'd0, 16'h8000, 16'h7FFF};
		feed_random(PER_PHASE);
		settle();

		run_phase(16'd0, 16'hFFFF, 16'hFFFF);
		run_phase(16'd1000, 16'd1000, 16'd4096);
		run_phase(16'd40000, 16'd100, 16'd4096);
		run_phase(16'd0, 16'd0, 16'd0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF);

		// unmapped index must leave the registers alone
		junk.index = REG_NONE;
		junk.data  = 16'($urandom);
		reg_writes.push_back(junk);
		no_gaps = 1'b1;
		run_phase(16'd500, 16'd3000, 16'd2048);
		no_gaps = 1'b0;

		run_phase(16'hFFFF, 16'd0, 16'd1);
		run_phase(16'd200, 16'd800, 16'd16384);
		for (int i = 0; i < 3; i++) begin
			near = 16'($urandom_range(20000));
			run_phase(near, near + 16'($urandom_range(30000)), 16'($urandom_range(16384, 512)));
		end
		run_phase(16'($urandom), 16'($urandom), 16'($urandom));

		settle();
		repeat (LAT) @(posedge clk);
		if (rgb_expected.size() != 0) begin
			$error("%0d expected words never arrived", rgb_expected.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("PASS depth_jet_colormap_top");
		end else begin
			$display("FAIL depth_jet_colormap_top");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/djc_pkg.sv
rtl/djc_div_cell.sv
rtl/depth_jet_colormap_top.sv
test/tb_depth_jet_colormap_top.sv
